// ===== hw/rtl/mqg_pkg.sv =====
// Shared types, constants and helper functions for the mouse quadrature generator.
// Depends on nothing; every other file but mqg_stream_if imports it.
package mqg_pkg;

   localparam int POSITION_FIELD_BITS = 12;
   localparam int POSITION_BITS_DEFAULT = 12;
   localparam int COUNT_BITS = 12;
   localparam int LIMIT_BITS = 11;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 11'd255;

   typedef enum logic {
      OP_SAMPLE = 1'b0,
      OP_POLL   = 1'b1
   } op_type;

   typedef struct packed {
      op_type                         op;
      logic [POSITION_FIELD_BITS-1:0] x_position;
      logic [POSITION_FIELD_BITS-1:0] y_position;
   } req_beat_type;

   typedef struct packed {
      logic [1:0] y_quadrature;
      logic [1:0] x_quadrature;
   } rsp_beat_type;

   typedef struct packed {
      logic         valid;
      req_beat_type beat;
   } stage_beat_type;

   // Phase 0,1,2,3 maps onto the Gray sequence 0,1,3,2.
   function automatic logic [1:0] gray2(input logic [1:0] phase);
      return {phase[1], phase[1] ^ phase[0]};
   endfunction

endpackage

// ===== hw/rtl/mqg_stream_if.sv =====
// Valid/ready stream interface with a typed payload.
// Depends on nothing; the payload type is supplied by the instantiating scope.
interface mqg_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/mqg_in_stage.sv =====
// Input register stage: captures one request beat per cycle unless the held beat is stalled by the engine.
// Depends on mqg_pkg and mqg_stream_if.
module mqg_in_stage
   import mqg_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   mqg_stream_if.sink     req_chan,
   input  logic           next_ready,
   output stage_beat_type stage
);

   logic         valid_ff, valid_in;
   req_beat_type beat_ff, beat_in;
   logic         advance;

   always_comb begin
      advance        = valid_ff && next_ready;
      req_chan.ready = !valid_ff || next_ready;
      valid_in       = valid_ff;
      beat_in        = beat_ff;
      if (req_chan.valid && req_chan.ready) begin
         valid_in = 1'b1;
         beat_in  = req_chan.payload;
      end else if (advance) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      beat_ff <= beat_in;
   end

   assign stage.valid = valid_ff;
   assign stage.beat  = beat_ff;

endmodule

// ===== hw/rtl/mqg_engine.sv =====
// Movement tracking, phase stepping and the result register.
// Depends on mqg_pkg and mqg_stream_if.
module mqg_engine
   import mqg_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write_enable,
   input  logic [LIMIT_BITS-1:0] csr_write_data,
   input  stage_beat_type        stage,
   output logic                  next_ready,
   mqg_stream_if.source          rsp_chan
);

   localparam int SUM_BITS = ((POSITION_BITS > COUNT_BITS) ? POSITION_BITS : COUNT_BITS) + 2;

   logic [LIMIT_BITS-1:0]       limit_ff;
   logic [POSITION_BITS-1:0]    last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [COUNT_BITS-1:0] pending_x_ff, pending_x_in, pending_y_ff, pending_y_in;
   logic [1:0]                  phase_x_ff, phase_x_in, phase_y_ff, phase_y_in;
   logic                        turn_is_y_ff, turn_is_y_in;
   logic                        baseline_ff, baseline_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   rsp_beat_type                rsp_beat_ff, rsp_beat_in;

   logic [POSITION_BITS-1:0]    cur_x, cur_y, diff_x, diff_y;
   logic signed [SUM_BITS-1:0]  sum_x, sum_y, lim_pos;
   logic                        fire, pend_x, pend_y, step_x, step_y;

   function automatic logic signed [COUNT_BITS-1:0] clamp_sum(
      input logic signed [SUM_BITS-1:0] sum,
      input logic signed [SUM_BITS-1:0] lim
   );
      logic signed [SUM_BITS-1:0] res;
      if (sum > lim) begin
         res = lim;
      end else if (sum < -lim) begin
         res = -lim;
      end else begin
         res = sum;
      end
      return COUNT_BITS'(res);
   endfunction

   always_comb begin
      next_ready = (stage.beat.op == OP_SAMPLE) || !rsp_valid_ff || rsp_chan.ready;
      fire       = stage.valid && next_ready;

      cur_x   = POSITION_BITS'(stage.beat.x_position);
      cur_y   = POSITION_BITS'(stage.beat.y_position);
      diff_x  = cur_x - last_x_ff;
      diff_y  = cur_y - last_y_ff;
      lim_pos = signed'(SUM_BITS'(limit_ff));
      sum_x   = SUM_BITS'(signed'(diff_x)) + SUM_BITS'(pending_x_ff);
      sum_y   = SUM_BITS'(signed'(diff_y)) + SUM_BITS'(pending_y_ff);

      pend_x = pending_x_ff != '0;
      pend_y = pending_y_ff != '0;
      step_x = pend_x && (!pend_y || !turn_is_y_ff);
      step_y = !step_x && pend_y;

      last_x_in    = last_x_ff;
      last_y_in    = last_y_ff;
      pending_x_in = pending_x_ff;
      pending_y_in = pending_y_ff;
      phase_x_in   = phase_x_ff;
      phase_y_in   = phase_y_ff;
      turn_is_y_in = turn_is_y_ff;
      baseline_in  = baseline_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_beat_in  = rsp_beat_ff;

      if (fire) begin
         case (stage.beat.op)
            OP_SAMPLE: begin
               if (baseline_ff) begin
                  pending_x_in = clamp_sum(sum_x, lim_pos);
                  pending_y_in = clamp_sum(sum_y, lim_pos);
               end
               last_x_in   = cur_x;
               last_y_in   = cur_y;
               baseline_in = 1'b1;
            end
            OP_POLL: begin
               if (step_x) begin
                  if (pending_x_ff > 0) begin
                     phase_x_in   = phase_x_ff - 2'd1;
                     pending_x_in = pending_x_ff - COUNT_BITS'(1);
                  end else begin
                     phase_x_in   = phase_x_ff + 2'd1;
                     pending_x_in = pending_x_ff + COUNT_BITS'(1);
                  end
                  turn_is_y_in = 1'b1;
               end else if (step_y) begin
                  if (pending_y_ff > 0) begin
                     phase_y_in   = phase_y_ff - 2'd1;
                     pending_y_in = pending_y_ff - COUNT_BITS'(1);
                  end else begin
                     phase_y_in   = phase_y_ff + 2'd1;
                     pending_y_in = pending_y_ff + COUNT_BITS'(1);
                  end
                  turn_is_y_in = 1'b0;
               end
               rsp_valid_in             = 1'b1;
               rsp_beat_in.x_quadrature = gray2(phase_x_in);
               rsp_beat_in.y_quadrature = gray2(phase_y_in);
            end
            default: begin
               rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= LIMIT_RESET;
         last_x_ff    <= '0;
         last_y_ff    <= '0;
         pending_x_ff <= '0;
         pending_y_ff <= '0;
         phase_x_ff   <= '0;
         phase_y_ff   <= '0;
         turn_is_y_ff <= 1'b0;
         baseline_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            limit_ff <= csr_write_data;
         end
         last_x_ff    <= last_x_in;
         last_y_ff    <= last_y_in;
         pending_x_ff <= pending_x_in;
         pending_y_ff <= pending_y_in;
         phase_x_ff   <= phase_x_in;
         phase_y_ff   <= phase_y_in;
         turn_is_y_ff <= turn_is_y_in;
         baseline_ff  <= baseline_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_beat_ff <= rsp_beat_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_beat_ff;

endmodule

// ===== hw/rtl/mouse_quadrature_generator.sv =====
// A poll beat is registered in the input stage, then in the result register, before the result port.
// Throughput: one beat per cycle unless a poll meets a stalled result; samples give no result.
// The result register lets a new request beat enter while a result beat waits.
// Synchronous reset clears positions, counts, phases and the baseline flag,
// and sets the count limit to 255.
module mouse_quadrature_generator
   import mqg_pkg::*;
#(
   parameter int POSITION_BITS = POSITION_BITS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   mqg_stream_if.sink            req_chan,
   mqg_stream_if.source          rsp_chan,
   input  logic                  csr_write_enable,
   input  logic [LIMIT_BITS-1:0] csr_write_data
);

   stage_beat_type stage;
   logic           next_ready;

   mqg_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .next_ready (next_ready),
      .stage      (stage)
   );

   mqg_engine #(
      .POSITION_BITS (POSITION_BITS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .stage            (stage),
      .next_ready       (next_ready),
      .rsp_chan         (rsp_chan)
   );

endmodule

// ===== hw/rtl/mqg_checker.sv =====
// Port-level checks for the mouse quadrature generator, bound to the top level.
// Depends on mqg_pkg.
module mqg_checker
   import mqg_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_beat_type rsp_payload
);

   rsp_beat_type last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff <= '0;
      end else if (rsp_valid && rsp_ready) begin
         last_ff <= rsp_payload;
      end
   end

   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result beat valid right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result beat changed");

   a_single_step: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |->
         $countones({rsp_payload.x_quadrature ^ last_ff.x_quadrature,
                     rsp_payload.y_quadrature ^ last_ff.y_quadrature}) <= 1)
      else $error("result beat moved more than one Gray step");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request side stalled with empty result register");

endmodule

bind mouse_quadrature_generator mqg_checker u_mqg_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_chan.valid),
   .req_ready   (req_chan.ready),
   .rsp_valid   (rsp_chan.valid),
   .rsp_ready   (rsp_chan.ready),
   .rsp_payload (rsp_chan.payload)
);
